/* rtl/dwfr_pkg.sv */
// ----------------------------------------------------------------------------
// dwfr_pkg
// Shared types, constants and the Daubechies tap table for the forward
// row wavelet transform.
// ----------------------------------------------------------------------------
package dwfr_pkg;

  localparam int TAP_W       = 16;  // Q2.14 taps
  localparam int FRAC_BITS   = 14;
  localparam int OUT_W       = 20;
  localparam int IDX_W       = 9;
  localparam int ORDER_W     = 4;
  localparam int TAP_CNT_W   = 5;   // holds a tap count up to 20
  localparam int MAX_ORDER   = 9;
  localparam int NUM_ORDERS  = 10;
  localparam int TABLE_TAPS  = 20;
  localparam int RESULT_CAP  = 10;  // pairs given per sample at most
  localparam int RES_CNT_W   = 4;
  localparam int OUT_MAX     = 524287;
  localparam int OUT_MIN     = -524288;

  typedef logic signed [TAP_W-1:0] tap_t;

  // Control from the sequencer to the dual MAC
  typedef struct packed {
    logic issue;   // a tap pair enters the pipeline
    logic clear;   // zero both accumulators before a new pair
    tap_t tap_lo;  // reversed tap
    tap_t tap_hi;  // alternating-sign tap
  } mac_ctl_t;

  // Row = filter order (D2 .. D20), column = tap, zero padded
  localparam tap_t TAP_TABLE [NUM_ORDERS][TABLE_TAPS] = '{
    '{16'sd16384, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
      16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
      16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd11190, 16'sd19382, 16'sd5194, -16'sd2998, 16'sd0, 16'sd0, 16'sd0,
      16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
      16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd7708, 16'sd18696, 16'sd10656, -16'sd3128, -16'sd1980, 16'sd816,
      16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
      16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd5338, 16'sd16563, 16'sd14618, -16'sd648, -16'sd4334, 16'sd715,
      16'sd762, -16'sd246, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
      16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd3710, 16'sd13991, 16'sd16783, 16'sd3207, -16'sd5614, -16'sd747,
      16'sd1797, -16'sd145, -16'sd292, 16'sd77, 16'sd0, 16'sd0, 16'sd0,
      16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd2584, 16'sd11461, 16'sd17404, 16'sd7305, -16'sd5243, -16'sd3007,
      16'sd2259, 16'sd638, -16'sd732, 16'sd13, 16'sd111, -16'sd25, 16'sd0,
      16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd1804, 16'sd9188, 16'sd16894, 16'sd10885, -16'sd3334, -16'sd5191,
      16'sd1652, 16'sd1868, -16'sd881, -16'sd384, 16'sd291, 16'sd10,
      -16'sd42, 16'sd8, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd1261, 16'sd7249, 16'sd15655, 16'sd13563, -16'sd367, -16'sd6581,
      16'sd11, 16'sd2983, -16'sd402, -16'sd1022, 16'sd324, 16'sd203,
      -16'sd113, -16'sd9, 16'sd16, -16'sd3, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd882, 16'sd5650, 16'sd14014, 16'sd15230, 16'sd3086, -16'sd6795,
      -16'sd2244, 16'sd3442, 16'sd712, -16'sd1567, 16'sd6, 16'sd518,
      -16'sd109, -16'sd99, 16'sd43, 16'sd5, -16'sd6, 16'sd1, 16'sd0, 16'sd0},
    '{16'sd618, 16'sd4360, 16'sd12216, 16'sd15952, 16'sd6515, -16'sd5789,
      -16'sd4540, 16'sd2951, 16'sd2156, -16'sd1654, -16'sd683, 16'sd770,
      16'sd84, -16'sd249, 16'sd32, 16'sd46, -16'sd16, -16'sd3, 16'sd2, 16'sd0}
  };

endpackage

/* rtl/dwfr_window.sv */
// ----------------------------------------------------------------------------
// dwfr_window
// Sample window: shift line of the newest samples with one registered
// read port addressed by age.
// ----------------------------------------------------------------------------
module dwfr_window #(
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_TAPS    = 20,
  parameter int WIN_AW      = $clog2(MAX_TAPS)
) (
  input  logic                          clk_i,
  input  logic                          shift_en_i,
  input  logic signed [SAMPLE_BITS-1:0] shift_data_i,
  input  logic                          rd_en_i,
  input  logic        [WIN_AW-1:0]      rd_addr_i,   // 0 = newest sample
  input  logic                          rd_zero_i,   // position outside the row
  output logic signed [SAMPLE_BITS-1:0] rd_data_o
);

  logic signed [SAMPLE_BITS-1:0] win_q [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (shift_en_i) begin
      win_q[0] <= shift_data_i;
      for (int i = 1; i < MAX_TAPS; i++) begin
        win_q[i] <= win_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= rd_zero_i ? '0 : win_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/dwfr_mac.sv */
// ----------------------------------------------------------------------------
// dwfr_mac
// Dual multiply-accumulate unit: one window sample against the low and
// the high tap, products registered, then accumulated; round and saturate.
// ----------------------------------------------------------------------------
module dwfr_mac #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  dwfr_pkg::mac_ctl_t               ctl_i,
  input  logic signed [SAMPLE_BITS-1:0]    sample_i,  // arrives in the cycle after issue
  output logic signed [dwfr_pkg::OUT_W-1:0] low_o,
  output logic signed [dwfr_pkg::OUT_W-1:0] high_o
);
  import dwfr_pkg::*;

  localparam int PROD_W = SAMPLE_BITS + TAP_W;
  localparam int ACC_W  = PROD_W + 5;
  localparam int RND_W  = ((ACC_W > 35) ? ACC_W : 35) + 1;
  localparam int Q_W    = RND_W - FRAC_BITS;

  tap_t                     tap_lo_q, tap_hi_q;
  logic                     vld_a_q, vld_b_q;
  logic signed [PROD_W-1:0] prod_lo_q, prod_hi_q;
  logic signed [ACC_W-1:0]  acc_lo_q, acc_hi_q;

  function automatic logic signed [OUT_W-1:0] round_sat(logic signed [ACC_W-1:0] acc);
    logic signed [RND_W-1:0] ext;
    logic signed [Q_W-1:0]   q;
    ext = RND_W'(acc) + RND_W'(signed'(32'sd8192));
    q   = Q_W'(ext >>> FRAC_BITS);
    if (q > Q_W'(OUT_MAX)) begin
      round_sat = OUT_W'(OUT_MAX);
    end else if (q < Q_W'(OUT_MIN)) begin
      round_sat = OUT_W'(OUT_MIN);
    end else begin
      round_sat = q[OUT_W-1:0];
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      vld_a_q <= ctl_i.issue;
      vld_b_q <= vld_a_q;
    end
  end

  // Taps are registered to line up with the registered window read
  always_ff @(posedge clk_i) begin
    if (ctl_i.issue) begin
      tap_lo_q <= ctl_i.tap_lo;
      tap_hi_q <= ctl_i.tap_hi;
    end
    if (vld_a_q) begin
      prod_lo_q <= PROD_W'(sample_i * tap_lo_q);
      prod_hi_q <= PROD_W'(sample_i * tap_hi_q);
    end
    if (ctl_i.clear) begin
      acc_lo_q <= '0;
      acc_hi_q <= '0;
    end else if (vld_b_q) begin
      acc_lo_q <= acc_lo_q + ACC_W'(prod_lo_q);
      acc_hi_q <= acc_hi_q + ACC_W'(prod_hi_q);
    end
  end

  assign low_o  = round_sat(acc_lo_q);
  assign high_o = round_sat(acc_hi_q);

endmodule

/* rtl/daubechies_wavelet_forward_row.sv */
// ----------------------------------------------------------------------------
// daubechies_wavelet_forward_row
// Streamed forward Daubechies (D2..D20) wavelet transform of one image row.
// ----------------------------------------------------------------------------
// Flow: each pair feeds T tap pairs (T = tap count, 2..20) to the dual
//   MAC, which then drains; a new sample is taken only once every pair the
//   last one completes is in the output register; a row end flushes up to T/2 - 1 pairs.
// Order: sample transfer, check, MAC feed, drain, move to the output register;
//   a held coefficient register stalls the sequencer until the sink takes it.
// Reset: sequencer idle, counters zero, order register and row order = 1.
// ----------------------------------------------------------------------------
module daubechies_wavelet_forward_row #(
  parameter int MAX_ROW     = 1024,
  parameter int MAX_TAPS    = 20,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write: wavelet_order
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [dwfr_pkg::ORDER_W-1:0]         cfg_data_i,
  // sample stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: sample [SAMPLE_BITS-1:0], zero padded to whole bytes
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
  input  logic                                 s_axis_tlast,   // last_in_row
  // coefficient stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tdata: low_value [19:0], high_value [39:20], pair_index [48:40], zero [55:49]
  output logic [55:0]                          m_axis_tdata,
  output logic                                 m_axis_tlast    // last_of_row
);
  import dwfr_pkg::*;

  localparam int CNT_W   = $clog2(MAX_ROW + 1);
  localparam int NP_W    = $clog2(MAX_ROW / 2 + 1);
  localparam int CMP_W   = CNT_W + 6;
  localparam int WIN_AW  = $clog2(MAX_TAPS);
  localparam int ORD_CAP = (MAX_TAPS / 2 - 1 < MAX_ORDER) ? MAX_TAPS / 2 - 1 : MAX_ORDER;

  // Sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;  // take a sample
  localparam logic [2:0] S_CHECK = 3'd1;  // decide whether a pair is due
  localparam logic [2:0] S_MAC   = 3'd2;  // feed T tap pairs to the MAC
  localparam logic [2:0] S_DRAIN = 3'd3;  // let the MAC pipeline empty
  localparam logic [2:0] S_EMIT  = 3'd4;  // move the pair to the output register

  logic [2:0]             state_q, state_d;
  logic [ORDER_W-1:0]     order_q;                 // configuration register
  logic [ORDER_W-1:0]     row_order_q, row_order_d;
  logic [TAP_CNT_W-1:0]   taps_q, taps_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [NP_W-1:0]        np_q, np_d;
  logic                   last_q, last_d;
  logic [RES_CNT_W-1:0]   res_cnt_q, res_cnt_d;
  logic [TAP_CNT_W-1:0]   k_q, k_d;
  logic signed [CMP_W:0]  back_q, back_d;
  logic                   drain_q, drain_d;

  logic                   out_vld_q, out_vld_d;
  logic [55:0]            out_data_q, out_data_d;
  logic                   out_last_q, out_last_d;

  logic                   s_xfer;
  logic [CNT_W-1:0]       count_inc;
  logic [ORDER_W-1:0]     ord_fit;
  logic [CMP_W-1:0]       cnt_ext, np_ext, half_ext;
  logic                   pair_due;
  logic                   out_free;
  logic [TAP_CNT_W-1:0]   lo_idx;
  tap_t                   c_lo, c_hi;
  mac_ctl_t               mac_ctl;
  logic                   rd_zero;
  logic signed [SAMPLE_BITS-1:0] win_data;
  logic signed [OUT_W-1:0] low_val, high_val;
  logic [NP_W+IDX_W-1:0]  np_wide;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign s_xfer        = s_axis_tvalid & s_axis_tready;

  // Clamp the requested order to the table and to the window depth
  assign ord_fit   = (order_q > ORDER_W'(ORD_CAP)) ? ORDER_W'(ORD_CAP) : order_q;
  assign count_inc = count_q + CNT_W'(1);

  assign cnt_ext  = CMP_W'(count_q);
  assign np_ext   = CMP_W'(np_q);
  assign half_ext = CMP_W'(count_q >> 1);

  // A pair is due once its last sample is in, or at row end for flushing
  assign pair_due = (res_cnt_q < RES_CNT_W'(RESULT_CAP)) && (np_ext < half_ext) &&
                    (last_q || ((np_ext << 1) + CMP_W'(taps_q) <= cnt_ext));

  assign out_free = !out_vld_q || m_axis_tready;

  // Tap selection: low takes the reversed taps, high the alternating sign
  assign lo_idx = taps_q - TAP_CNT_W'(1) - k_q;
  assign c_lo   = TAP_TABLE[row_order_q][lo_idx];
  assign c_hi   = k_q[0] ? TAP_TABLE[row_order_q][k_q] : -TAP_TABLE[row_order_q][k_q];

  assign rd_zero = (back_q < 0) || (back_q >= (CMP_W+1)'(MAX_TAPS));

  assign np_wide = (NP_W+IDX_W)'(np_q);

  always_comb begin
    mac_ctl        = '0;
    mac_ctl.tap_lo = c_lo;
    mac_ctl.tap_hi = c_hi;
    mac_ctl.issue  = (state_q == S_MAC);
    mac_ctl.clear  = (state_q == S_CHECK) && pair_due;
  end

  always_comb begin
    state_d     = state_q;
    row_order_d = row_order_q;
    taps_d      = taps_q;
    count_d     = count_q;
    np_d        = np_q;
    last_d      = last_q;
    res_cnt_d   = res_cnt_q;
    k_d         = k_q;
    back_d      = back_q;
    drain_d     = drain_q;
    out_vld_d   = out_vld_q && !m_axis_tready;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      S_IDLE: begin
        if (s_xfer) begin
          // Latch the filter at the first sample of a row
          if (count_q == '0) begin
            row_order_d = ord_fit;
            taps_d      = TAP_CNT_W'({ord_fit, 1'b0}) + TAP_CNT_W'(2);
          end
          count_d   = count_inc;
          last_d    = s_axis_tlast || (count_inc >= CNT_W'(MAX_ROW));
          res_cnt_d = '0;
          state_d   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (pair_due) begin
          k_d     = '0;
          back_d  = $signed({1'b0, cnt_ext - CMP_W'(1) - (np_ext << 1)});
          state_d = S_MAC;
        end else begin
          if (last_q) begin
            count_d = '0;
            np_d    = '0;
          end
          state_d = S_IDLE;
        end
      end
      S_MAC: begin
        k_d    = k_q + TAP_CNT_W'(1);
        back_d = back_q - (CMP_W+1)'(1);
        if (k_q == taps_q - TAP_CNT_W'(1)) begin
          drain_d = 1'b0;
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        drain_d = 1'b1;
        if (drain_q) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_data_d = {7'b0, np_wide[IDX_W-1:0], high_val, low_val};
          out_last_d = last_q && ((np_ext + CMP_W'(1)) >= half_ext);
          np_d       = np_q + NP_W'(1);
          res_cnt_d  = res_cnt_q + RES_CNT_W'(1);
          state_d    = S_CHECK;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      order_q     <= ORDER_W'(1);
      row_order_q <= ORDER_W'(1);
      taps_q      <= TAP_CNT_W'(4);
      count_q     <= '0;
      np_q        <= '0;
      last_q      <= 1'b0;
      res_cnt_q   <= '0;
      k_q         <= '0;
      back_q      <= '0;
      drain_q     <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        order_q <= cfg_data_i;
      end
      row_order_q <= row_order_d;
      taps_q      <= taps_d;
      count_q     <= count_d;
      np_q        <= np_d;
      last_q      <= last_d;
      res_cnt_q   <= res_cnt_d;
      k_q         <= k_d;
      back_q      <= back_d;
      drain_q     <= drain_d;
      out_vld_q   <= out_vld_d;
    end
  end

  // Output payload, held while the sink stalls
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  dwfr_window #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_TAPS    (MAX_TAPS),
    .WIN_AW      (WIN_AW)
  ) u_window (
    .clk_i        (clk_i),
    .shift_en_i   (s_xfer),
    .shift_data_i (s_axis_tdata[SAMPLE_BITS-1:0]),
    .rd_en_i      (mac_ctl.issue),
    .rd_addr_i    (back_q[WIN_AW-1:0]),
    .rd_zero_i    (rd_zero),
    .rd_data_o    (win_data)
  );

  dwfr_mac #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (mac_ctl),
    .sample_i (win_data),
    .low_o    (low_val),
    .high_o   (high_val)
  );

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb - forward Daubechies row transform bench
// Streams image rows of random length and content into the block under
// several filter orders, predicts every low/high coefficient pair in
// software and compares each coefficient transfer against the oldest
// prediction. Idle gaps fall on both streams, the coefficient side is
// held off once for a long stretch, and the order register is rewritten
// only while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD       = 10;
  localparam int MAX_ROW          = 1024;
  localparam int MAX_TAPS         = 20;
  localparam int PAIR_CAP         = 10;    // pairs a single sample can release
  localparam int COEF_MAX         = 524287;
  localparam int COEF_MIN         = -524288;
  localparam int SETTLE_CYCLES    = 60;    // outlasts a pair on the longest filter
  localparam int SINK_HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS     = 150;
  localparam int REPORT_LIMIT     = 10;

  // Q2.14 Daubechies taps, one row per order (D2 .. D20), zero padded
  localparam int DB_TAPS [10][20] = '{
    '{16384, 16384, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{11190, 19382, 5194, -2998, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{7708, 18696, 10656, -3128, -1980, 816, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
      0, 0},
    '{5338, 16563, 14618, -648, -4334, 715, 762, -246, 0, 0, 0, 0, 0, 0, 0, 0, 0,
      0, 0, 0},
    '{3710, 13991, 16783, 3207, -5614, -747, 1797, -145, -292, 77, 0, 0, 0, 0, 0,
      0, 0, 0, 0, 0},
    '{2584, 11461, 17404, 7305, -5243, -3007, 2259, 638, -732, 13, 111, -25, 0,
      0, 0, 0, 0, 0, 0, 0},
    '{1804, 9188, 16894, 10885, -3334, -5191, 1652, 1868, -881, -384, 291, 10,
      -42, 8, 0, 0, 0, 0, 0, 0},
    '{1261, 7249, 15655, 13563, -367, -6581, 11, 2983, -402, -1022, 324, 203,
      -113, -9, 16, -3, 0, 0, 0, 0},
    '{882, 5650, 14014, 15230, 3086, -6795, -2244, 3442, 712, -1567, 6, 518,
      -109, -99, 43, 5, -6, 1, 0, 0},
    '{618, 4360, 12216, 15952, 6515, -5789, -4540, 2951, 2156, -1654, -683, 770,
      84, -249, 32, 46, -16, -3, 2, 0}
  };

  typedef struct {
    logic signed [19:0] low_v;
    logic signed [19:0] high_v;
    logic [8:0]         idx;
    logic               row_last;
  } coef_pair_t;

  // --------------------------------------------------------------------------
  // Coefficient scoreboard: tracks the row window in software and keeps the
  // pairs each accepted sample is bound to release, oldest first.
  // --------------------------------------------------------------------------
  class coef_scoreboard;
    logic [3:0]         order_reg;
    int                 row_order;
    logic signed [15:0] window [MAX_TAPS];
    int                 seen;
    int                 next_pair;
    coef_pair_t         pending_pairs [$];
    int                 mismatches;

    function new();
      order_reg  = 4'd1;
      row_order  = 1;
      seen       = 0;
      next_pair  = 0;
      mismatches = 0;
      foreach (window[i]) window[i] = '0;
    endfunction

    function void set_order(logic [3:0] value);
      order_reg = value;
    endfunction

    // Round half up at the Q2.14 point, then clip to the 20-bit range
    function logic signed [19:0] round_clip(longint acc);
      longint q;
      q = (acc + 64'sd8192) >>> 14;
      if (q > COEF_MAX) q = COEF_MAX;
      if (q < COEF_MIN) q = COEF_MIN;
      return q[19:0];
    endfunction

    function void note_sample(logic [15:0] raw, bit last_in);
      coef_pair_t exp_pair;
      longint     lo_acc, hi_acc, v;
      int         taps, half, pos, back, made;
      bit         row_end;
      // the order is latched on the first sample of each row
      if (seen == 0) row_order = (order_reg > 4'd9) ? 9 : int'(order_reg);
      for (int k = MAX_TAPS - 1; k > 0; k--) window[k] = window[k-1];
      window[0] = raw;
      seen++;
      row_end = last_in || (seen >= MAX_ROW);
      taps    = 2 * row_order + 2;
      half    = seen / 2;
      made    = 0;
      while (made < PAIR_CAP && next_pair < half &&
             (row_end || 2 * next_pair + taps <= seen)) begin
        lo_acc = 0;
        hi_acc = 0;
        for (int k = 0; k < taps; k++) begin
          pos  = 2 * next_pair + k;
          back = seen - 1 - pos;
          // samples past the row end read as zero
          v = (pos < seen && back < MAX_TAPS) ? longint'(window[back]) : 64'sd0;
          lo_acc += DB_TAPS[row_order][taps-1-k] * v;
          if (k % 2) hi_acc += DB_TAPS[row_order][k] * v;
          else hi_acc -= DB_TAPS[row_order][k] * v;
        end
        exp_pair.low_v  = round_clip(lo_acc);
        exp_pair.high_v = round_clip(hi_acc);
        exp_pair.idx    = 9'(next_pair);
        next_pair++;
        exp_pair.row_last = row_end && (next_pair >= half);
        pending_pairs.push_back(exp_pair);
        made++;
      end
      if (row_end) begin
        foreach (window[i]) window[i] = '0;
        seen      = 0;
        next_pair = 0;
      end
    endfunction

    function void check_pair(logic [55:0] data, logic flag);
      coef_pair_t exp_pair;
      if (pending_pairs.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: unexpected pair low=%0d high=%0d idx=%0d last=%0b", $realtime,
                   $signed(data[19:0]), $signed(data[39:20]), data[48:40], flag);
        return;
      end
      exp_pair = pending_pairs.pop_front();
      if (data[19:0] !== exp_pair.low_v || data[39:20] !== exp_pair.high_v ||
          data[48:40] !== exp_pair.idx || flag !== exp_pair.row_last) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: pair mismatch exp low=%0d high=%0d idx=%0d last=%0b, got low=%0d %s",
                   $realtime, exp_pair.low_v, exp_pair.high_v, exp_pair.idx,
                   exp_pair.row_last, $signed(data[19:0]),
                   $sformatf("high=%0d idx=%0d last=%0b", $signed(data[39:20]),
                             data[48:40], flag));
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block under test
  // --------------------------------------------------------------------------
  logic                             clk_i         = 1'b0;
  logic                             rst_ni        = 1'b0;
  logic                             cfg_valid_i   = 1'b0;
  logic                             cfg_ready_o;
  logic [dwfr_pkg::ORDER_W-1:0]     cfg_data_i    = '0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [15:0]                      s_axis_tdata  = '0;  // sample [15:0]
  logic                             s_axis_tlast  = 1'b0; // last_in_row
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  // low_value [19:0], high_value [39:20], pair_index [48:40], zero [55:49]
  logic [55:0]                      m_axis_tdata;
  logic                             m_axis_tlast;        // last_of_row

  daubechies_wavelet_forward_row i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  coef_scoreboard sb = new();
  bit             src_burst      = 1'b0;  // suppress sample gaps while set
  bit             stall_sink_req = 1'b0;  // ask the sink for its long hold-off

  // Mostly back to back, sometimes a short gap, now and then a long pause
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] rand_sample();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic int pick_row_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 1;
    if (r < 75) return $urandom_range(2, 12);
    return $urandom_range(13, 40);
  endfunction

  // Offer one sample and hold it until the transfer; the caller sits on an edge
  task automatic send_sample(input logic [15:0] smp, input bit last);
    int gap;
    gap = src_burst ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_sample(smp, last);
  endtask

  task automatic send_row(input int len);
    for (int k = 0; k < len; k++) send_sample(rand_sample(), k == len - 1);
  endtask

  // Drop the sample stream, wait out every pending pair, then let the
  // block finish any work that releases no pair
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_pairs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_order(input logic [3:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_order(value);
    cfg_valid_i <= 1'b0;
  endtask

  // Check every coefficient transfer against the oldest prediction
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_pair(m_axis_tdata, m_axis_tlast);
  end

  // Coefficient sink: alternate ready stretches and gaps; once on request,
  // hold off long enough for the block to back up into the sample stream
  initial begin : coef_sink
    int  len;
    bit  held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (stall_sink_req && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk_i);
      end else begin
        len = pick_gap();
        if (len > 0) begin
          m_axis_tready <= 1'b0;
          repeat (len) @(posedge clk_i);
        end
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end
    end
  end

  // Hard stop well beyond the slowest legal run
  initial begin : watchdog
    #50_000_000;
    $display("daubechies_wavelet_forward_row verification failed");
    $finish;
  end

  initial begin : stimulus
    int rand_items;
    int phase;
    int leftover;
    logic [3:0] order;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // D2: full-scale pair, then a one-sample row (no pair, no flag), then
    // an odd row whose final sample feeds no pair
    write_order(4'd0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    settle();

    // D20: a short row flushes every pair with zeros past the end
    write_order(4'd9);
    for (int k = 0; k < 6; k++) send_sample(k % 2 ? 16'h7FFF : 16'h8000, k == 5);
    settle();

    // order above nine acts as nine
    write_order(4'd15);
    send_sample(16'h0001, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h7FFF, 1'b1);
    settle();

    // D4 row interrupted by a write of D12: the new order waits for the next row
    write_order(4'd1);
    for (int k = 0; k < 3; k++) send_sample(rand_sample(), 1'b0);
    settle();
    write_order(4'd5);
    for (int k = 0; k < 3; k++) send_sample(rand_sample(), k == 2);
    send_row(4);
    settle();

    // Random rows across many orders, extremes first
    rand_items = 0;
    phase      = 0;
    while (rand_items < RANDOM_ITEMS) begin
      case (phase)
        0: order = 4'd0;
        1: order = 4'd9;
        2: order = 4'd10;
        3: order = 4'd3;
        default: order = $urandom_range(0, 15);
      endcase
      write_order(order);
      src_burst = (phase % 3 == 2);
      repeat ($urandom_range(2, 5)) begin
        phase = phase;  // keep the loop body a plain block
        begin
          int len;
          len = pick_row_len();
          send_row(len);
          rand_items += len;
        end
      end
      settle();
      phase++;
    end

    // Overlong row on D2: no tlast, the sample that reaches the row limit
    // closes it; the sink holds off partway so the block backs up
    write_order(4'd0);
    src_burst = 1'b1;
    for (int k = 0; k < MAX_ROW; k++) begin
      if (k == 64) stall_sink_req = 1'b1;
      send_sample(rand_sample(), 1'b0);
    end
    src_burst = 1'b0;
    settle();
    write_order(4'd7);
    send_row(9);
    settle();

    leftover = sb.pending_pairs.size();
    if (leftover != 0) begin
      $display("%0d coefficient pairs never arrived", leftover);
      sb.mismatches += leftover;
    end
    if (sb.mismatches == 0) begin
      $display("daubechies_wavelet_forward_row verification clean");
    end else begin
      $display("daubechies_wavelet_forward_row verification failed");
    end
    $finish;
  end

endmodule
